// ===== hw/rtl/ckvp_pkg.sv =====
// ----------------------------------------------------------------------------
// ckvp_pkg
// Types, codes and helpers shared by the key=value connection-string parser.
// ----------------------------------------------------------------------------
package ckvp_pkg;

   // parser phase, 4-bit code; codes 9..15 never occur and decode as skip
   typedef enum logic [3:0] {
      PH_SKIP    = 4'd0,
      PH_KEY     = 4'd1,
      PH_KEYSP   = 4'd2,
      PH_VSKIP   = 4'd3,
      PH_UNQ     = 4'd4,
      PH_UESC    = 4'd5,
      PH_QUOTED  = 4'd6,
      PH_QESC    = 4'd7,
      PH_ABORTED = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      EV_KEY   = 3'd0,
      EV_VAL   = 3'd1,
      EV_PAIR  = 3'd2,
      EV_ABORT = 3'd3,
      EV_DONE  = 3'd4
   } event_type;

   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   // result queue depth (two pushes per beat worst case)
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      event_type  kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   typedef struct packed {
      phase_type  phase_next;
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } step_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic result_type make_result(input event_type k, input logic [7:0] c);
      result_type r;
      r.kind = k;
      r.data = ((k == EV_KEY) || (k == EV_VAL)) ? c : 8'd0;
      r.last = (k == EV_DONE);
      return r;
   endfunction

endpackage

// ===== hw/rtl/ckvp_step.sv =====
// ----------------------------------------------------------------------------
// ckvp_step
// Next-phase and result decode for one input beat of the parser.
// ----------------------------------------------------------------------------
module ckvp_step (
   input  ckvp_pkg::phase_type phase,
   input  logic [7:0]          text_byte,
   input  logic                is_end,
   output ckvp_pkg::step_type  step
);

   always_comb begin
      step.phase_next = phase;
      step.count      = 2'd0;
      step.res0       = ckvp_pkg::make_result(ckvp_pkg::EV_DONE, 8'd0);
      step.res1       = ckvp_pkg::make_result(ckvp_pkg::EV_DONE, 8'd0);

      if (is_end) begin
         step.phase_next = ckvp_pkg::PH_SKIP;
         case (phase)
            ckvp_pkg::PH_KEY, ckvp_pkg::PH_KEYSP,
            ckvp_pkg::PH_QUOTED, ckvp_pkg::PH_QESC: begin
               step.count = 2'd2;
               step.res0  = ckvp_pkg::make_result(ckvp_pkg::EV_ABORT, 8'd0);
            end
            ckvp_pkg::PH_VSKIP, ckvp_pkg::PH_UNQ, ckvp_pkg::PH_UESC: begin
               step.count = 2'd2;
               step.res0  = ckvp_pkg::make_result(ckvp_pkg::EV_PAIR, 8'd0);
            end
            default: begin
               step.count = 2'd1;
            end
         endcase
      end else begin
         case (phase)
            ckvp_pkg::PH_KEY: begin
               if (text_byte == ckvp_pkg::CH_EQ) begin
                  step.phase_next = ckvp_pkg::PH_VSKIP;
               end else if (ckvp_pkg::is_space(text_byte)) begin
                  step.phase_next = ckvp_pkg::PH_KEYSP;
               end else begin
                  step.count = 2'd1;
                  step.res0  = ckvp_pkg::make_result(ckvp_pkg::EV_KEY, text_byte);
               end
            end
            ckvp_pkg::PH_KEYSP: begin
               if (text_byte == ckvp_pkg::CH_EQ) begin
                  step.phase_next = ckvp_pkg::PH_VSKIP;
               end else if (!ckvp_pkg::is_space(text_byte)) begin
                  step.count      = 2'd1;
                  step.res0       = ckvp_pkg::make_result(ckvp_pkg::EV_ABORT, 8'd0);
                  step.phase_next = ckvp_pkg::PH_ABORTED;
               end
            end
            ckvp_pkg::PH_VSKIP: begin
               if (ckvp_pkg::is_space(text_byte)) begin
                  step.phase_next = ckvp_pkg::PH_VSKIP;
               end else if (text_byte == ckvp_pkg::CH_QUOTE) begin
                  step.phase_next = ckvp_pkg::PH_QUOTED;
               end else if (text_byte == ckvp_pkg::CH_BSLASH) begin
                  step.phase_next = ckvp_pkg::PH_UESC;
               end else begin
                  step.count      = 2'd1;
                  step.res0       = ckvp_pkg::make_result(ckvp_pkg::EV_VAL, text_byte);
                  step.phase_next = ckvp_pkg::PH_UNQ;
               end
            end
            ckvp_pkg::PH_UNQ: begin
               if (ckvp_pkg::is_space(text_byte)) begin
                  step.count      = 2'd1;
                  step.res0       = ckvp_pkg::make_result(ckvp_pkg::EV_PAIR, 8'd0);
                  step.phase_next = ckvp_pkg::PH_SKIP;
               end else if (text_byte == ckvp_pkg::CH_BSLASH) begin
                  step.phase_next = ckvp_pkg::PH_UESC;
               end else begin
                  step.count = 2'd1;
                  step.res0  = ckvp_pkg::make_result(ckvp_pkg::EV_VAL, text_byte);
               end
            end
            ckvp_pkg::PH_UESC: begin
               step.count      = 2'd1;
               step.res0       = ckvp_pkg::make_result(ckvp_pkg::EV_VAL, text_byte);
               step.phase_next = ckvp_pkg::PH_UNQ;
            end
            ckvp_pkg::PH_QUOTED: begin
               if (text_byte == ckvp_pkg::CH_BSLASH) begin
                  step.phase_next = ckvp_pkg::PH_QESC;
               end else if (text_byte == ckvp_pkg::CH_QUOTE) begin
                  step.count      = 2'd1;
                  step.res0       = ckvp_pkg::make_result(ckvp_pkg::EV_PAIR, 8'd0);
                  step.phase_next = ckvp_pkg::PH_SKIP;
               end else begin
                  step.count = 2'd1;
                  step.res0  = ckvp_pkg::make_result(ckvp_pkg::EV_VAL, text_byte);
               end
            end
            ckvp_pkg::PH_QESC: begin
               step.count      = 2'd1;
               step.res0       = ckvp_pkg::make_result(ckvp_pkg::EV_VAL, text_byte);
               step.phase_next = ckvp_pkg::PH_QUOTED;
            end
            ckvp_pkg::PH_ABORTED: begin
               step.phase_next = ckvp_pkg::PH_ABORTED;
            end
            default: begin
               // skip space, also for unused codes
               if (ckvp_pkg::is_space(text_byte)) begin
                  step.phase_next = ckvp_pkg::PH_SKIP;
               end else if (text_byte == ckvp_pkg::CH_EQ) begin
                  step.phase_next = ckvp_pkg::PH_VSKIP;
               end else begin
                  step.count      = 2'd1;
                  step.res0       = ckvp_pkg::make_result(ckvp_pkg::EV_KEY, text_byte);
                  step.phase_next = ckvp_pkg::PH_KEY;
               end
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/conninfo_keyvalue_parser.sv =====
// ----------------------------------------------------------------------------
// conninfo_keyvalue_parser
// Streaming key=value connection-string parser with a small result queue.
// ----------------------------------------------------------------------------
// The parser takes one string byte per beat and updates its phase register in
// the same cycle, so a byte can be accepted every clock while req_tready is
// high. Each beat yields zero or one result; the end-of-string beat
// (req_tlast) yields one or two (pair complete or aborted, then string done),
// so it can put two results on the result port. Results wait in a four-entry
// queue; req_tready drops only when fewer than two entries are free. An
// accepted beat's results are registered in the queue before they reach rsp.
module conninfo_keyvalue_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // is_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [2:0] event_kind
   output logic       rsp_tlast    // final_res
);

   ckvp_pkg::phase_type  phase_ff, phase_in;
   ckvp_pkg::step_type   step;
   ckvp_pkg::result_type queue_ff [ckvp_pkg::QDEPTH];
   logic [ckvp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ckvp_pkg::QPTR_W-1:0] wr_ptr_nxt;
   logic [ckvp_pkg::QCNT_W-1:0] count_ff, count_in;
   logic       accept, pop;
   logic [1:0] push_n;

   ckvp_step u_step (
      .phase     (phase_ff),
      .text_byte (req_tdata),
      .is_end    (req_tlast),
      .step      (step)
   );

   assign req_tready = (count_ff <= ckvp_pkg::QCNT_W'(ckvp_pkg::QDEPTH - 2));
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign push_n     = accept ? step.count : 2'd0;
   assign wr_ptr_nxt = wr_ptr_ff + ckvp_pkg::QPTR_W'(1);

   always_comb begin
      phase_in  = accept ? step.phase_next : phase_ff;
      wr_ptr_in = wr_ptr_ff + ckvp_pkg::QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + ckvp_pkg::QPTR_W'(pop);
      count_in  = count_ff + ckvp_pkg::QCNT_W'(push_n) - ckvp_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ckvp_pkg::PH_SKIP;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= step.res0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_nxt] <= step.res1;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = queue_ff[rd_ptr_ff].data;
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;

endmodule

// ===== hw/rtl/ckvp_checker.sv =====
// ----------------------------------------------------------------------------
// ckvp_checker
// Port-level checks for the connection-string parser, bound to the top level.
// ----------------------------------------------------------------------------
module ckvp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // tlast only on string done, and string done always carries tlast
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == ckvp_pkg::EV_DONE)))
      else $error("tlast does not match string-done kind");

   // only key and value beats carry a byte
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ckvp_pkg::EV_KEY) && (rsp_tuser != ckvp_pkg::EV_VAL)
         |-> (rsp_tdata == 8'd0))
      else $error("non-data result carries a byte");

   // idle after reset; end beat always produces a result next cycle
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_end_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("end beat gave no result");

endmodule

bind conninfo_keyvalue_parser ckvp_checker u_ckvp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
